/* hw/rtl/ght_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg: shared types and codes for the generational handle table
// Transaction structs, opcode and status codes, controller states and the
// command/status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 10;
    localparam int GEN_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CHECK   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  handle_index;
        logic [GEN_W-1:0]    handle_gen;
    } ght_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  new_index;
        logic [GEN_W-1:0]    new_gen;
    } ght_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_EXEC
    } ght_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;          // latch the incoming transaction
        logic rd_stack;         // read the top of the free stack
        logic rd_slot;          // read the slot memory
        logic slot_from_stack;  // slot address comes from the popped entry
        logic exec;             // update state and register the result
    } ght_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_create;
        logic stack_nonempty;
    } ght_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/generational_handle_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table: slot map of generational handles
// Hands out (index, generation) handles, retires them and checks liveness.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low. busy stays high until
//   the result has been registered.
//   Result channel: done is high for exactly one cycle with rsp valid; the
//   receiver cannot stall and must take it in that cycle.
//   Sequencing: the command is taken in IDLE and decoded in DECODE; a create
//   that reuses a freed slot passes through POP, which first pops the free
//   stack, and the result is registered in EXEC. A new command is taken in
//   the same cycle the result is shown, so a transaction is taken only when
//   the last one is through. The steps follow from the registered reads of
//   the free stack and slot memories, which run in series.
//   Reset: clears the fill count of the free stack and the high-water mark;
//   slot entries at or above the high-water mark are never used before a
//   create writes them, so no clearing pass runs and the block is ready as
//   soon as reset is released.
// ----------------------------------------------------------------------------
module generational_handle_table #(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  ght_pkg::ght_req_t  req,
    output logic               done,
    output ght_pkg::ght_rsp_t  rsp
);
    import ght_pkg::*;

    ght_cmd_t  cmd;
    ght_stat_t stat;

    // Sequence each transaction: decode, optional pop, execute
    ght_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Hold slot state, free stack, counters and the result register
    ght_dp #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

/* hw/rtl/ght_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_ctrl: sequencing controller for the generational handle table
// Steps each transaction through decode, optional stack pop, and execute.
// ----------------------------------------------------------------------------
module ght_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  ght_pkg::ght_stat_t     stat,
    output ght_pkg::ght_cmd_t      cmd
);
    import ght_pkg::*;

    ght_state_t state_reg;
    ght_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.is_create)
                begin
                    // reuse a freed slot when one exists, else go straight on
                    if (stat.stack_nonempty)
                    begin
                        cmd.rd_stack = 1'b1;
                        state_next   = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
                else
                begin
                    cmd.rd_slot = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_POP:
            begin
                cmd.rd_slot         = 1'b1;
                cmd.slot_from_stack = 1'b1;
                state_next          = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/ght_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_dp: datapath for the generational handle table
// Slot memory (alive bit and generation), free stack memory, fill counters
// and the result register.
// ----------------------------------------------------------------------------
module ght_dp #(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  ght_pkg::ght_req_t      req,
    input  ght_pkg::ght_cmd_t      cmd,
    output ght_pkg::ght_stat_t     stat,
    output logic                   done,
    output ght_pkg::ght_rsp_t      rsp
);
    import ght_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;

    // slot entry: alive bit on top, generation below
    logic [GEN_BITS:0] slot_mem [SLOTS];
    logic [IDX_W-1:0]  stack_mem [SLOTS];

    ght_req_t          req_reg;
    logic [GEN_BITS:0] slot_rd_reg;
    logic [IDX_W-1:0]  stack_rd_reg;
    logic [IDX_W-1:0]  slot_addr_reg;
    ght_rsp_t          rsp_reg;
    ght_rsp_t          rsp_next;
    logic              done_reg;
    logic [CNT_W-1:0]  fc_reg;
    logic [CNT_W-1:0]  fc_next;
    logic [CNT_W-1:0]  hw_reg;
    logic [CNT_W-1:0]  hw_next;

    logic [IDX_W-1:0]    slot_raddr;
    logic [IDX_W-1:0]    slot_waddr;
    logic [GEN_BITS:0]   slot_wdata;
    logic                slot_we;
    logic                stack_we;
    logic [IDX_W-1:0]    pop_addr;
    logic [IDX_W-1:0]    push_addr;
    logic                hw_full;
    logic                in_range;
    logic                live;
    logic [GEN_BITS-1:0] cur_gen;

    assign stat.is_create      = (req_reg.opcode == OP_CREATE);
    assign stat.stack_nonempty = (fc_reg != '0);

    assign pop_addr   = IDX_W'(fc_reg - CNT_W'(1));
    assign push_addr  = IDX_W'(fc_reg);
    assign slot_raddr = cmd.slot_from_stack ? stack_rd_reg : IDX_W'(req_reg.handle_index);
    assign hw_full    = (hw_reg == CNT_W'(SLOTS));
    assign cur_gen    = slot_rd_reg[GEN_BITS-1:0];
    assign in_range   = (32'(req_reg.handle_index) < 32'(hw_reg));
    assign live       = in_range && slot_rd_reg[GEN_BITS]
                        && (CMP_W'(req_reg.handle_gen) == CMP_W'(cur_gen));

    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = slot_addr_reg;
        slot_wdata = '0;
        stack_we   = 1'b0;
        fc_next    = fc_reg;
        hw_next    = hw_reg;
        rsp_next   = '{status: STATUS_STALE, new_index: '0, new_gen: '0};
        if (cmd.exec)
        begin
            unique case (req_reg.opcode)
                OP_CREATE:
                begin
                    priority if (fc_reg != '0)
                    begin
                        // pop: revive the freed slot with its current generation
                        slot_we    = 1'b1;
                        slot_wdata = {1'b1, cur_gen};
                        fc_next    = fc_reg - CNT_W'(1);
                        rsp_next   = '{status: STATUS_OK,
                                       new_index: INDEX_W'(slot_addr_reg),
                                       new_gen: GEN_W'(cur_gen)};
                    end
                    else if (!hw_full)
                    begin
                        // fresh slot at the high-water mark, generation zero
                        slot_we    = 1'b1;
                        slot_waddr = IDX_W'(hw_reg);
                        slot_wdata = {1'b1, {GEN_BITS{1'b0}}};
                        hw_next    = hw_reg + CNT_W'(1);
                        rsp_next   = '{status: STATUS_OK,
                                       new_index: INDEX_W'(hw_reg),
                                       new_gen: '0};
                    end
                    else
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                end
                OP_DESTROY:
                begin
                    if (live)
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = {1'b0, cur_gen + GEN_BITS'(1)};
                        if (fc_reg != CNT_W'(SLOTS))
                        begin
                            stack_we = 1'b1;
                            fc_next  = fc_reg + CNT_W'(1);
                        end
                        rsp_next.status = STATUS_OK;
                    end
                end
                OP_CHECK:
                begin
                    rsp_next.status = live ? STATUS_OK : STATUS_STALE;
                end
                default:
                begin
                    rsp_next.status = STATUS_STALE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg   <= '0;
            hw_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fc_reg   <= fc_next;
            hw_reg   <= hw_next;
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.rd_slot)
        begin
            slot_addr_reg <= slot_raddr;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (cmd.rd_slot)
        begin
            slot_rd_reg <= slot_mem[slot_raddr];
        end
        if (stack_we)
        begin
            stack_mem[push_addr] <= slot_addr_reg;
        end
        if (cmd.rd_stack)
        begin
            stack_rd_reg <= stack_mem[pop_addr];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_hw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hw_reg >= $past(hw_reg)))
        else $error("high-water mark decreased");

    a_stack_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= hw_reg)
        else $error("free stack holds more slots than were handed out");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe lasted more than one cycle");

    a_push_kills: assert property (@(posedge clk) disable iff (!rst_n)
        stack_we |-> (slot_we && !slot_wdata[GEN_BITS]))
        else $error("slot pushed without being marked dead");

endmodule
`default_nettype wire
